// ===== rtl/gpm_pkg.sv =====
// package with constants and helpers for the glob pattern matcher
`timescale 1ns / 1ps
`default_nettype none
package gpm_pkg;
   localparam int MaxLen = 64;
   localparam int AddrW = $clog2(MaxLen);
   localparam int LenW = $clog2(MaxLen + 1);

   localparam logic [1:0] CMD_PAT = 2'd0;
   localparam logic [1:0] CMD_NAME = 2'd1;
   localparam logic [1:0] CMD_EVAL = 2'd2;

   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_OPEN = 8'h5B;
   localparam logic [7:0] CH_CLOSE = 8'h5D;
   localparam logic [7:0] CH_DASH = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   function automatic logic [7:0] fold(input logic [7:0] c, input logic cs);
      if (!cs && c >= 8'h61 && c <= 8'h7A) begin
         return c - 8'h20;
      end
      return c;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/glob_pattern_matcher.sv =====
// top level of the glob pattern matcher: string memories and evaluation sequencer
//
// channel | ports                         | handshake
// req     | req_cmd, req_char_byte        | start high while busy low
// rsp     | rsp_matched                   | rsp_valid strobe, one cycle
// csr     | csr_case_sensitive            | csr_valid and csr_ready
//
// appends never raise busy. evaluate reads pattern and name from two memories through
// registered reads: a literal or question mark takes one name byte, a star scans the run
// of bytes up to the next star, question mark or end and then compares it at each
// candidate position, and a class refills its four byte window for each element or
// skipped byte. the strobe comes in the cycle after the decision and busy drops in the
// cycle after it. reset is synchronous and clears the lengths and the register; the
// receiver cannot stall, busy holds off requests.
`timescale 1ns / 1ps
`default_nettype none
module glob_pattern_matcher (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_cmd,
   input  wire logic [7:0] req_char_byte,
   output logic            rsp_valid,
   output logic            rsp_matched,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_case_sensitive
);
   localparam int AW = gpm_pkg::AddrW;
   localparam int LW = gpm_pkg::LenW;
   localparam int PW = LW + 1;

   // states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_FETCH  = 4'd1;
   localparam logic [3:0] S_DISP   = 4'd2;
   localparam logic [3:0] S_SCAN   = 4'd3;
   localparam logic [3:0] S_SRCH   = 4'd4;
   localparam logic [3:0] S_CMP    = 4'd5;
   localparam logic [3:0] S_CLS    = 4'd6;
   localparam logic [3:0] S_CLSE   = 4'd7;
   localparam logic [3:0] S_SKIP   = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;
   localparam logic [3:0] S_CLSW   = 4'd10;

   logic [7:0] pmem [gpm_pkg::MaxLen];
   logic [7:0] nmem [gpm_pkg::MaxLen];
   logic [LW-1:0] plen_ff, nlen_ff;
   logic cs_ff;
   logic [3:0] state_ff, state_in;
   logic [PW-1:0] p_ff, p_in, n_ff, n_in, st_ff, st_in, ln_ff, ln_in, pos_ff, pos_in,
                  j_ff, j_in;
   logic [PW-1:0] pa_ff, pa_in; // pattern read address
   logic [PW-1:0] na_ff, na_in;
   logic [7:0] prd_ff, nrd_ff;
   logic [7:0] win_ff [4]; // class window p..p+3
   logic [7:0] win_in [4];
   logic [2:0] wcnt_ff, wcnt_in;
   logic found_ff, found_in;
   logic [7:0] nb_ff, nb_in;
   logic rv_in, rm_in;
   logic [7:0] b;
   logic [7:0] pv, nv;
   logic w2;

   assign busy = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign b = (req_char_byte == gpm_pkg::CH_BSLASH || req_char_byte == gpm_pkg::CH_COLON)
              ? gpm_pkg::CH_SLASH : req_char_byte;

   // memory reads: out of range reads give zero end mark
   always_ff @(posedge clock) begin
      prd_ff <= pmem[pa_in[AW-1:0]];
      nrd_ff <= nmem[na_in[AW-1:0]];
      if (start && !busy && b != 8'd0 && plen_ff < LW'(gpm_pkg::MaxLen - 1)
          && req_cmd == gpm_pkg::CMD_PAT) begin
         pmem[plen_ff[AW-1:0]] <= b;
      end
      if (start && !busy && b != 8'd0 && nlen_ff < LW'(gpm_pkg::MaxLen - 1)
          && req_cmd == gpm_pkg::CMD_NAME) begin
         nmem[nlen_ff[AW-1:0]] <= b;
      end
   end

   logic pa_ok_ff, na_ok_ff;
   always_ff @(posedge clock) begin
      pa_ok_ff <= pa_in < PW'(plen_ff);
      na_ok_ff <= na_in < PW'(nlen_ff);
   end
   assign pv = pa_ok_ff ? prd_ff : 8'd0;
   assign nv = na_ok_ff ? nrd_ff : 8'd0;
   assign w2 = win_ff[2] != 8'd0;

   always_comb begin
      state_in = state_ff;
      p_in = p_ff; n_in = n_ff; st_in = st_ff; ln_in = ln_ff; pos_in = pos_ff; j_in = j_ff;
      pa_in = pa_ff; na_in = na_ff;
      win_in = win_ff; wcnt_in = wcnt_ff; found_in = found_ff; nb_in = nb_ff;
      rv_in = 1'b0; rm_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start && req_cmd == gpm_pkg::CMD_EVAL) begin
               p_in = '0; n_in = '0; pa_in = '0; na_in = '0;
               state_in = S_DISP;
            end
         end
         S_FETCH: begin
            state_in = S_DISP;
         end
         S_DISP: begin
            // pv = pat[p], nv = name[n]
            if (pv == 8'd0) begin
               rv_in = 1'b1; rm_in = 1'b1; state_in = S_DONE;
            end else if (pv == gpm_pkg::CH_STAR) begin
               p_in = p_ff + 1'b1; st_in = p_ff + 1'b1; ln_in = '0;
               pa_in = p_ff + 1'b1; state_in = S_SCAN;
            end else if (pv == gpm_pkg::CH_QUEST) begin
               if (n_ff >= PW'(nlen_ff)) begin
                  rv_in = 1'b1; state_in = S_DONE;
               end else begin
                  p_in = p_ff + 1'b1; n_in = n_ff + 1'b1;
                  pa_in = p_ff + 1'b1; na_in = n_ff + 1'b1; state_in = S_FETCH;
               end
            end else if (pv == gpm_pkg::CH_OPEN) begin
               // j all ones marks the first window, where a doubled bracket is checked
               nb_in = gpm_pkg::fold(nv, cs_ff);
               found_in = 1'b0; j_in = '1;
               p_in = p_ff + 1'b1; pa_in = p_ff + 1'b1;
               wcnt_in = '0; state_in = S_CLSW;
            end else begin
               if (gpm_pkg::fold(pv, cs_ff) != gpm_pkg::fold(nv, cs_ff)) begin
                  rv_in = 1'b1; state_in = S_DONE;
               end else begin
                  p_in = p_ff + 1'b1; n_in = n_ff + 1'b1;
                  pa_in = p_ff + 1'b1; na_in = n_ff + 1'b1; state_in = S_FETCH;
               end
            end
         end
         S_SCAN: begin
            if (pv == 8'd0 || pv == gpm_pkg::CH_STAR || pv == gpm_pkg::CH_QUEST) begin
               if (ln_ff == '0) begin
                  pa_in = p_ff; na_in = n_ff; state_in = S_FETCH;
               end else begin
                  pos_in = n_ff; j_in = '0; state_in = S_SRCH;
               end
            end else begin
               p_in = p_ff + 1'b1; ln_in = ln_ff + 1'b1; pa_in = p_ff + 1'b1;
            end
         end
         S_SRCH: begin
            if (pos_ff + ln_ff > PW'(nlen_ff)) begin
               rv_in = 1'b1; state_in = S_DONE;
            end else begin
               j_in = '0; pa_in = st_ff; na_in = pos_ff; state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (gpm_pkg::fold(pv, cs_ff) != gpm_pkg::fold(nv, cs_ff)) begin
               pos_in = pos_ff + 1'b1; state_in = S_SRCH;
            end else if (j_ff + 1'b1 == ln_ff) begin
               n_in = pos_ff + ln_ff; pa_in = p_ff; na_in = pos_ff + ln_ff;
               state_in = S_FETCH;
            end else begin
               j_in = j_ff + 1'b1;
               pa_in = st_ff + j_ff + 1'b1; na_in = pos_ff + j_ff + 1'b1;
            end
         end
         S_CLSW: begin
            // fill a four byte window at p
            win_in[wcnt_ff[1:0]] = pv;
            pa_in = pa_ff + 1'b1;
            if (wcnt_ff == 3'd3) begin
               state_in = S_CLS;
            end
            wcnt_in = wcnt_ff + 1'b1;
         end
         S_CLS: begin
            if (j_ff == '1) begin
               if (win_ff[0] == gpm_pkg::CH_OPEN) begin
                  // doubled bracket: p already at the second bracket
                  pa_in = p_ff; na_in = n_ff; state_in = S_FETCH;
               end else if (n_ff >= PW'(nlen_ff)) begin
                  rv_in = 1'b1; state_in = S_DONE;
               end else begin
                  j_in = '0; state_in = S_CLSE;
               end
            end else if (found_ff) begin
               state_in = S_SKIP;
            end else begin
               state_in = S_CLSE;
            end
         end
         S_CLSE: begin
            if (win_ff[0] == 8'd0 || (win_ff[0] == gpm_pkg::CH_CLOSE
                && win_ff[1] != gpm_pkg::CH_CLOSE)) begin
               rv_in = 1'b1; state_in = S_DONE;
            end else if (win_ff[1] == gpm_pkg::CH_DASH && w2
                         && (win_ff[2] != gpm_pkg::CH_CLOSE
                             || win_ff[3] == gpm_pkg::CH_CLOSE)) begin
               if (nb_ff >= gpm_pkg::fold(win_ff[0], cs_ff)
                   && nb_ff <= gpm_pkg::fold(win_ff[2], cs_ff)) begin
                  found_in = 1'b1;
               end
               p_in = p_ff + 2'd3; pa_in = p_ff + 2'd3; wcnt_in = '0; state_in = S_CLSW;
            end else begin
               if (gpm_pkg::fold(win_ff[0], cs_ff) == nb_ff) begin
                  found_in = 1'b1;
               end
               p_in = p_ff + 1'b1; pa_in = p_ff + 1'b1; wcnt_in = '0; state_in = S_CLSW;
            end
         end
         S_SKIP: begin
            if (win_ff[0] == 8'd0 || (win_ff[0] == gpm_pkg::CH_CLOSE
                && win_ff[1] != gpm_pkg::CH_CLOSE)) begin
               p_in = p_ff + 1'b1; n_in = n_ff + 1'b1;
               pa_in = p_ff + 1'b1; na_in = n_ff + 1'b1; state_in = S_FETCH;
            end else begin
               p_in = p_ff + 1'b1; pa_in = p_ff + 1'b1; wcnt_in = '0;
               state_in = S_CLSW;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         plen_ff <= '0;
         nlen_ff <= '0;
         cs_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid <= rv_in;
         if (csr_valid && csr_ready) begin
            cs_ff <= csr_case_sensitive;
         end
         if (start && !busy && b != 8'd0) begin
            if (req_cmd == gpm_pkg::CMD_PAT && plen_ff < LW'(gpm_pkg::MaxLen - 1)) begin
               plen_ff <= plen_ff + 1'b1;
            end
            if (req_cmd == gpm_pkg::CMD_NAME && nlen_ff < LW'(gpm_pkg::MaxLen - 1)) begin
               nlen_ff <= nlen_ff + 1'b1;
            end
         end
         if (rv_in) begin
            plen_ff <= '0;
            nlen_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in; n_ff <= n_in; st_ff <= st_in; ln_ff <= ln_in; pos_ff <= pos_in;
      j_ff <= j_in; pa_ff <= pa_in; na_ff <= na_in; wcnt_ff <= wcnt_in;
      found_ff <= found_in; nb_ff <= nb_in; rsp_matched <= rm_in;
      for (int i = 0; i < 4; i++) begin
         win_ff[i] <= win_in[i];
      end
   end
endmodule
`default_nettype wire
